[hw/rtl/stt_pkg.sv]
// Shared types, constants and helper functions of the schema text tokenizer.
package stt_pkg;

  localparam int unsigned OffsetBits   = 32;
  localparam int unsigned KeywordChars = 9;
  localparam int unsigned PosBits      = 24;
  localparam int unsigned NumKeywords  = 8;
  localparam int unsigned MaxKwLen     = 9;

  localparam logic [PosBits-1:0] PosMax = {PosBits{1'b1}};

  typedef enum logic [7:0] {
    MODE_BASE   = 8'b0000_0001,
    MODE_SLASH  = 8'b0000_0010,
    MODE_LINE   = 8'b0000_0100,
    MODE_BLOCK  = 8'b0000_1000,
    MODE_STAR   = 8'b0001_0000,
    MODE_STRING = 8'b0010_0000,
    MODE_WORD   = 8'b0100_0000,
    MODE_NUMBER = 8'b1000_0000
  } mode_e;

  typedef enum logic [1:0] {
    STATUS_TOKEN = 2'd0,
    STATUS_UNEXP = 2'd1,
    STATUS_BADENC = 2'd2
  } status_e;

  localparam logic [4:0] KindSemi    = 5'd0;
  localparam logic [4:0] KindLParen  = 5'd1;
  localparam logic [4:0] KindRParen  = 5'd2;
  localparam logic [4:0] KindLBrace  = 5'd3;
  localparam logic [4:0] KindRBrace  = 5'd4;
  localparam logic [4:0] KindComma   = 5'd5;
  localparam logic [4:0] KindString  = 5'd6;
  localparam logic [4:0] KindNumber  = 5'd7;
  localparam logic [4:0] KindIdent   = 5'd8;
  localparam logic [4:0] KindKwBase  = 5'd9;
  localparam logic [4:0] KindEnd     = 5'd17;

  typedef logic [MaxKwLen*8-1:0] kw_text_t;

  function automatic kw_text_t kw_text(input logic [2:0] idx);
    kw_text_t t;
    t = '0;
    case (idx)
      3'd0: t = {24'h0, "ytitne"};
      3'd1: t = "etubirtta";
      3'd2: t = {8'h0, "noitaler"};
      3'd3: t = {32'h0, "latot"};
      3'd4: t = "seificeps";
      3'd5: t = {48'h0, "yek"};
      3'd6: t = "evisulcxe";
      3'd7: t = {32'h0, "saila"};
      default: t = '0;
    endcase
    return t;
  endfunction

  function automatic logic [3:0] kw_len(input logic [2:0] idx);
    logic [3:0] l;
    case (idx)
      3'd0: l = 4'd6;
      3'd1: l = 4'd9;
      3'd2: l = 4'd8;
      3'd3: l = 4'd5;
      3'd4: l = 4'd9;
      3'd5: l = 4'd3;
      3'd6: l = 4'd9;
      3'd7: l = 4'd5;
      default: l = 4'd0;
    endcase
    return l;
  endfunction

  function automatic logic [PosBits-1:0] sat_add(input logic [PosBits-1:0] a,
                                                 input logic [PosBits-1:0] b);
    logic [PosBits:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[PosBits] ? PosMax : s[PosBits-1:0];
  endfunction

  typedef struct packed {
    logic [1:0]  status;
    logic [4:0]  kind;
    logic [31:0] offset;
    logic [31:0] length;
    logic [PosBits-1:0] line;
    logic [PosBits-1:0] column;
    logic [PosBits-1:0] byte_column;
    logic [31:0] line_start;
    logic        last;
  } result_t;

endpackage

[hw/rtl/stt_keyword_match.sv]
// Keyword lookup over the word buffer.
module stt_keyword_match import stt_pkg::*; #(
  parameter int unsigned KwChars = KeywordChars,
  parameter int unsigned CntBits = $clog2(KwChars + 2)
) (
  input  logic [KwChars*8-1:0] word_i,
  input  logic [CntBits-1:0]   count_i,
  output logic [4:0]           kind_o
);

  always_comb begin
    kind_o = KindIdent;
    for (int i = int'(NumKeywords) - 1; i >= 0; i--) begin
      logic same;
      kw_text_t t;
      t = kw_text(3'(i));
      same = (count_i == CntBits'(kw_len(3'(i))));
      for (int j = 0; j < MaxKwLen; j++) begin
        if (j < int'(kw_len(3'(i))) && j < KwChars) begin
          if (word_i[j*8 +: 8] != t[j*8 +: 8]) same = 1'b0;
        end
      end
      if (same) kind_o = KindKwBase + 5'(i);
    end
  end

endmodule

[hw/rtl/stt_out_queue.sv]
// Two-entry result queue that decouples the scanner from the output stall.
module stt_out_queue import stt_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  logic    two_i,
  input  result_t first_i,
  input  result_t second_i,
  output logic    room_o,
  output logic    valid_o,
  input  logic    stall_i,
  output result_t head_o
);

  result_t     ent_q [2];
  result_t     ent_d [2];
  logic [1:0]  cnt_q, cnt_d;
  logic        pop;

  assign pop     = (cnt_q != 2'd0) && !stall_i;
  assign valid_o = cnt_q != 2'd0;
  assign head_o  = ent_q[0];
  assign room_o  = (cnt_q == 2'd0) || (cnt_q == 2'd1 && pop);

  always_comb begin
    logic [1:0] c;
    ent_d = ent_q;
    c = cnt_q;
    if (pop) begin
      ent_d[0] = ent_q[1];
      c = c - 2'd1;
    end
    if (push_i) begin
      if (c == 2'd0) begin
        ent_d[0] = first_i;
        ent_d[1] = second_i;
      end else begin
        ent_d[1] = first_i;
      end
      c = c + (two_i ? 2'd2 : 2'd1);
    end
    cnt_d = c;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

endmodule

[hw/rtl/schema_text_tokenizer.sv]
// Top level of the schema text tokenizer.
// One decoded character is taken per cycle when the result queue has room; the
// scan is combinational from the registered state and pushes zero, one or
// two results into a two-entry queue. An item that yields two results needs the
// queue empty (or draining) and fills it, so the next character waits for a pop.
module schema_text_tokenizer import stt_pkg::*; #(
  parameter int unsigned OFFSET_BITS   = OffsetBits,
  parameter int unsigned KEYWORD_CHARS = KeywordChars
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [20:0] code_point_i,
  input  logic [2:0]  char_bytes_i,
  input  logic        end_of_text_i,
  input  logic        bad_encoding_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [4:0]  token_kind_o,
  output logic [31:0] token_offset_o,
  output logic [31:0] token_length_o,
  output logic [23:0] line_number_o,
  output logic [23:0] column_number_o,
  output logic [23:0] line_byte_column_o,
  output logic [31:0] line_start_offset_o,
  output logic        last_of_run_o
);

  localparam int unsigned CntBits = $clog2(KEYWORD_CHARS + 2);
  localparam int unsigned OB = OFFSET_BITS;

  typedef struct packed {
    logic [OB-1:0]      off;
    logic [PosBits-1:0] line;
    logic [PosBits-1:0] col;
    logic [PosBits-1:0] bcol;
    logic [OB-1:0]      lstart;
  } pos_t;

  mode_e        mode_q, mode_d;
  logic         open_q, open_d;
  pos_t         st_q, st_d, cur_q, cur_d;
  logic [7:0]   buf_q [KEYWORD_CHARS];
  logic [7:0]   buf_d [KEYWORD_CHARS];
  logic [CntBits-1:0] cnt_q, cnt_d;

  logic         room, accept, push, two;
  result_t      r0, r1;
  logic [4:0]   wkind;
  logic [KEYWORD_CHARS*8-1:0] word_flat;

  assign in_stall_o = !room;
  assign accept     = in_valid_i && room;

  always_comb begin
    for (int i = 0; i < KEYWORD_CHARS; i++) word_flat[i*8 +: 8] = buf_q[i];
  end

  stt_keyword_match #(.KwChars(KEYWORD_CHARS), .CntBits(CntBits)) u_kw (
    .word_i (word_flat),
    .count_i(cnt_q),
    .kind_o (wkind)
  );

  function automatic result_t mk(input logic [1:0] s, input logic [4:0] k,
                                 input pos_t p, input logic [OB-1:0] len);
    result_t r;
    r.status      = s;
    r.kind        = k;
    r.offset      = 32'(p.off);
    r.length      = 32'(len);
    r.line        = p.line;
    r.column      = p.col;
    r.byte_column = p.bcol;
    r.line_start  = 32'(p.lstart);
    r.last        = 1'b0;
    return r;
  endfunction

  always_comb begin
    logic [20:0] c;
    logic        eof, err, rescan, wch, dig, ws, punct, lf;
    logic [4:0]  pk;
    logic [OB-1:0] bytes, here_end;
    pos_t        st, posr;
    mode_e       m;
    logic        op;
    logic [1:0]  n;
    logic [CntBits-1:0] wc;

    c     = code_point_i;
    eof   = end_of_text_i;
    bytes = OB'(char_bytes_i);
    wch   = (c >= 21'd97 && c <= 21'd122) || (c >= 21'd65 && c <= 21'd90) ||
            c == 21'd95 || c > 21'd127;
    dig   = c >= 21'd48 && c <= 21'd57;
    lf    = c == 21'd10;
    ws    = eof || c == 21'd32 || lf || c == 21'd13 || c == 21'd9;
    punct = 1'b1;
    case (c)
      21'd59: pk = KindSemi;
      21'd40: pk = KindLParen;
      21'd41: pk = KindRParen;
      21'd123: pk = KindLBrace;
      21'd125: pk = KindRBrace;
      21'd44: pk = KindComma;
      default: begin
        pk = KindSemi;
        punct = 1'b0;
      end
    endcase
    here_end = cur_q.off + bytes;

    mode_d = mode_q;
    open_d = open_q;
    st_d   = st_q;
    cur_d  = cur_q;
    buf_d  = buf_q;
    cnt_d  = cnt_q;
    r0 = mk(STATUS_TOKEN, KindSemi, cur_q, '0);
    r1 = r0;
    push = 1'b0;
    two  = 1'b0;

    m = mode_q;
    op = open_q;
    st = open_q ? st_q : cur_q;
    wc = cnt_q;
    n = 2'd0;
    err = 1'b0;
    rescan = 1'b0;

    // first pass: any mode
    case (m)
      MODE_BASE: ;
      MODE_SLASH: begin
        if (!eof && c == 21'd47) m = MODE_LINE;
        else if (!eof && c == 21'd42) m = MODE_BLOCK;
        else err = 1'b1;
      end
      MODE_LINE: begin
        if (!eof && lf) begin
          m = MODE_BASE;
          op = 1'b0;
        end
      end
      MODE_BLOCK: begin
        if (eof) err = 1'b1;
        else if (c == 21'd42) m = MODE_STAR;
      end
      MODE_STAR: begin
        if (eof) err = 1'b1;
        else if (c == 21'd47) begin
          m = MODE_BASE;
          op = 1'b0;
        end else m = MODE_BLOCK;
      end
      MODE_STRING: begin
        if (eof || lf) err = 1'b1;
        else if (c == 21'd34) begin
          r0 = mk(STATUS_TOKEN, KindString, st, cur_q.off - st.off);
          n = 2'd1;
          m = MODE_BASE;
          op = 1'b0;
        end
      end
      default: begin
        if (!eof && (wch || dig)) begin
          if (m == MODE_WORD) begin
            if (wc < CntBits'(KEYWORD_CHARS)) begin
              buf_d[wc[$clog2(KEYWORD_CHARS)-1:0]] = c <= 21'd127 ? c[7:0] : 8'd0;
              wc = wc + CntBits'(1);
            end else wc = CntBits'(KEYWORD_CHARS + 1);
          end
        end else begin
          r0 = mk(STATUS_TOKEN, m == MODE_WORD ? wkind : KindNumber, st,
                  cur_q.off - st.off);
          n = 2'd1;
          m = MODE_BASE;
          op = 1'b0;
          rescan = 1'b1;
        end
      end
    endcase

    // base pass: direct or rescanned character
    if (mode_q == MODE_BASE || rescan) begin
      if (!op) st = cur_q;
      op = 1'b1;
      if (ws) op = 1'b0;
      else if (punct) begin
        if (n == 2'd0) r0 = mk(STATUS_TOKEN, pk, st, here_end - st.off);
        else r1 = mk(STATUS_TOKEN, pk, st, here_end - st.off);
        n = n + 2'd1;
        op = 1'b0;
      end else if (c == 21'd47) m = MODE_SLASH;
      else if (c == 21'd34) begin
        m = MODE_STRING;
        op = 1'b0;
      end else if (wch) begin
        m = MODE_WORD;
        buf_d[0] = c <= 21'd127 ? c[7:0] : 8'd0;
        wc = CntBits'(1);
      end else if (dig) m = MODE_NUMBER;
      else err = 1'b1;
    end else begin
      op = (mode_q == MODE_LINE || mode_q == MODE_STAR || mode_q == MODE_STRING) ? op : 1'b1;
      if (mode_q == MODE_LINE && !(!eof && lf)) op = 1'b1;
      if (mode_q == MODE_STAR && !(!eof && c == 21'd47)) op = 1'b1;
      if (mode_q == MODE_STRING && !(!eof && c == 21'd34)) op = 1'b1;
    end

    posr = cur_q;
    if (!eof && bad_encoding_i) begin
      r0 = mk(STATUS_BADENC, KindSemi, posr, '0);
      n = 2'd1;
      err = 1'b1;
    end else if (err || eof) begin
      if (n == 2'd0) r0 = mk(err ? STATUS_UNEXP : STATUS_TOKEN,
                             err ? KindSemi : KindEnd, posr, '0);
      else r1 = mk(err ? STATUS_UNEXP : STATUS_TOKEN, err ? KindSemi : KindEnd, posr, '0);
      n = n + 2'd1;
    end
    if (n == 2'd1) r0.last = 1'b1;
    if (n == 2'd2) r1.last = 1'b1;

    if (accept) begin
      push = n != 2'd0;
      two  = n == 2'd2;
      if (err || eof) begin
        mode_d = MODE_BASE;
        open_d = 1'b0;
        cnt_d  = '0;
        st_d   = '{off: '0, line: PosBits'(1), col: PosBits'(1), bcol: '0, lstart: '0};
        cur_d  = st_d;
      end else begin
        mode_d = m;
        open_d = op;
        st_d   = st;
        cnt_d  = wc;
        cur_d.off = here_end;
        if (lf) begin
          cur_d.line   = sat_add(cur_q.line, PosBits'(1));
          cur_d.col    = PosBits'(1);
          cur_d.bcol   = '0;
          cur_d.lstart = here_end;
        end else begin
          cur_d.col  = sat_add(cur_q.col, PosBits'(1));
          cur_d.bcol = sat_add(cur_q.bcol, PosBits'(char_bytes_i));
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_BASE;
      open_q <= 1'b0;
      cnt_q  <= '0;
      st_q   <= '{off: '0, line: PosBits'(1), col: PosBits'(1), bcol: '0, lstart: '0};
      cur_q  <= '{off: '0, line: PosBits'(1), col: PosBits'(1), bcol: '0, lstart: '0};
    end else begin
      mode_q <= mode_d;
      open_q <= open_d;
      cnt_q  <= cnt_d;
      st_q   <= st_d;
      cur_q  <= cur_d;
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
  end

  result_t head;

  stt_out_queue u_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .two_i   (two),
    .first_i (r0),
    .second_i(r1),
    .room_o  (room),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .head_o  (head)
  );

  assign status_o            = head.status;
  assign token_kind_o        = head.kind;
  assign token_offset_o      = head.offset;
  assign token_length_o      = head.length;
  assign line_number_o       = head.line;
  assign column_number_o     = head.column;
  assign line_byte_column_o  = head.byte_column;
  assign line_start_offset_o = head.line_start;
  assign last_of_run_o       = head.last;

endmodule
